/* hw/rtl/i2cbm_pkg.sv */
// shared codes, widths and field positions of the i2c bit-level master
package i2cbm_pkg;

  localparam int unsigned CmdW       = 3;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned TickW      = 16;
  localparam int unsigned PhaseW     = 5;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;

  typedef logic [CmdW-1:0]   cmd_t;
  typedef logic [PhaseW-1:0] phase_t;

  localparam cmd_t CMD_NONE  = 3'd0;
  localparam cmd_t CMD_START = 3'd1;
  localparam cmd_t CMD_STOP  = 3'd2;
  localparam cmd_t CMD_WRITE = 3'd3;
  localparam cmd_t CMD_READ  = 3'd4;

  localparam logic [TickW-1:0] DEFAULT_PHASE_TICKS = 16'd1;

  // phase numbers that matter in the byte sequences
  localparam phase_t PH_DATA_END  = 5'd16;
  localparam phase_t PH_ACK_HIGH  = 5'd17;
  localparam phase_t PH_LAST_BYTE = 5'd18;
  localparam phase_t PH_LAST_ACK  = 5'd19;
  localparam phase_t PH_LAST_COND = 5'd2;

  // output tdata bit positions
  localparam int unsigned OUT_SCL   = 0;
  localparam int unsigned OUT_SDA   = 1;
  localparam int unsigned OUT_BUSY  = 2;
  localparam int unsigned OUT_DONE  = 3;
  localparam int unsigned OUT_RX_LO = 4;
  localparam int unsigned OUT_NOACK = 12;

endpackage

/* hw/rtl/i2c_bit_level_master.sv */
// i2c bit-level master: start, stop, byte write and byte read sequencer, one transaction per tick
//
// each input transaction is one bus tick and produces exactly one result transaction, so the
// block runs at one transaction per clock cycle; the bus state advances in a single pass of
// logic between the state registers and a result register, and the result register decouples
// the two streams (input is taken while a result waits, as long as the consumer takes it).
// a command (start, stop, write byte with ack check, read byte) is taken only while idle and
// every bus phase lasts phase_ticks ticks (zero counts as one); commands while busy and unknown
// codes are ignored. the user writes phase_ticks over the cfg channel while idle; not enforced.
module i2c_bit_level_master
  import i2cbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream, tdata from bit 0: command[2:0], tx_byte[10:3], send_ack[11], sda_in[12]
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  // result stream, tdata from bit 0: scl_level[0], sda_level[1], busy_res[2], done_res[3],
  // rx_byte[11:4], no_ack[12]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  // configuration write: phase_ticks
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TickW-1:0]    cfg_data
);

  // input fields
  cmd_t             command;
  logic [ByteW-1:0] tx_byte;
  logic             send_ack;
  logic             sda_in;

  assign command  = in_tdata[2:0];
  assign tx_byte  = in_tdata[10:3];
  assign send_ack = in_tdata[11];
  assign sda_in   = in_tdata[12];

  // state
  logic [TickW-1:0] phase_ticks_r;
  cmd_t             active_r, active_nxt;
  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] shift_r, shift_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             no_ack_r, no_ack_nxt;
  logic             ack_sel_r, ack_sel_nxt;
  logic [ByteW-1:0] rx_hold_r, rx_hold_nxt;

  // result register
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  logic in_accept;
  assign in_tready = ~out_valid_r | out_tready;
  assign in_accept = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  // effective values for this tick, after a possible command launch
  logic             launch;
  cmd_t             cmd_e;
  phase_t           ph_e;
  logic [ByteW-1:0] shift_e;
  logic [TickW-1:0] tick_e, tick_inc, limit;
  logic             ack_sel_e;
  logic             phase_end;
  phase_t           last_ph;
  logic             done;

  always_comb begin
    limit    = (phase_ticks_r == '0) ? TickW'(1) : phase_ticks_r;
    launch   = (active_r == CMD_NONE) &&
               ((command == CMD_START) || (command == CMD_STOP) ||
                (command == CMD_WRITE) || (command == CMD_READ));
    cmd_e    = launch ? command : active_r;
    ph_e     = launch ? '0 : phase_r;
    tick_e   = launch ? '0 : tick_r;
    shift_e  = launch ? ((command == CMD_WRITE) ? tx_byte : '0) : shift_r;
    ack_sel_e = launch ? send_ack : ack_sel_r;

    tick_inc  = tick_e + TickW'(1);
    phase_end = (cmd_e != CMD_NONE) && (tick_inc >= limit);

    // last phase of the running sequence; read with ack gets an extra release phase
    if ((cmd_e == CMD_START) || (cmd_e == CMD_STOP)) begin
      last_ph = PH_LAST_COND;
    end else if ((cmd_e == CMD_READ) && ack_sel_e) begin
      last_ph = PH_LAST_ACK;
    end else begin
      last_ph = PH_LAST_BYTE;
    end

    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    shift_nxt   = shift_e;
    no_ack_nxt  = no_ack_r;
    ack_sel_nxt = ack_sel_e;
    rx_hold_nxt = rx_hold_r;
    active_nxt  = cmd_e;
    phase_nxt   = ph_e;
    tick_nxt    = (cmd_e != CMD_NONE) ? tick_inc : tick_e;
    done        = 1'b0;

    // bus levels of the current phase
    unique case (cmd_e)
      CMD_START: begin
        if (ph_e == 5'd0) begin
          scl_nxt = 1'b1; sda_nxt = 1'b1;
        end else if (ph_e == 5'd1) begin
          scl_nxt = 1'b1; sda_nxt = 1'b0;
        end else begin
          scl_nxt = 1'b0; sda_nxt = 1'b0;
        end
      end
      CMD_STOP: begin
        // first phase keeps scl where it is
        if (ph_e == 5'd0) begin
          sda_nxt = 1'b0;
        end else if (ph_e == 5'd1) begin
          scl_nxt = 1'b1; sda_nxt = 1'b0;
        end else begin
          scl_nxt = 1'b1; sda_nxt = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (ph_e < PH_DATA_END) begin
          scl_nxt = ph_e[0]; sda_nxt = shift_e[ByteW-1];
        end else begin
          scl_nxt = (ph_e == PH_ACK_HIGH); sda_nxt = 1'b1;
        end
      end
      CMD_READ: begin
        if (ph_e < PH_DATA_END) begin
          scl_nxt = ~ph_e[0]; sda_nxt = 1'b1;
        end else begin
          scl_nxt = (ph_e == PH_ACK_HIGH);
          sda_nxt = ~((ph_e < PH_LAST_ACK) && ack_sel_e);
        end
      end
      default: begin
      end
    endcase

    if (phase_end) begin
      tick_nxt = '0;
      // end-of-phase shifting and sampling
      if (cmd_e == CMD_WRITE) begin
        if ((ph_e < PH_DATA_END) && ph_e[0]) begin
          shift_nxt = {shift_e[ByteW-2:0], 1'b0};
        end else if (ph_e == PH_ACK_HIGH) begin
          no_ack_nxt = sda_in;
        end
      end else if ((cmd_e == CMD_READ) && (ph_e < PH_DATA_END) && !ph_e[0]) begin
        shift_nxt = {shift_e[ByteW-2:0], sda_in};
      end

      if (ph_e >= last_ph) begin
        if (cmd_e == CMD_READ) begin
          rx_hold_nxt = shift_nxt;
        end
        active_nxt = CMD_NONE;
        phase_nxt  = '0;
        done       = 1'b1;
      end else begin
        phase_nxt = ph_e + PhaseW'(1);
      end
    end

    out_data_nxt                         = '0;
    out_data_nxt[OUT_SCL]                = scl_nxt;
    out_data_nxt[OUT_SDA]                = sda_nxt;
    out_data_nxt[OUT_BUSY]               = (active_nxt != CMD_NONE);
    out_data_nxt[OUT_DONE]               = done;
    out_data_nxt[OUT_RX_LO +: ByteW]     = rx_hold_nxt;
    out_data_nxt[OUT_NOACK]              = no_ack_nxt;
  end

  // bus state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= CMD_NONE;
      phase_r   <= '0;
      shift_r   <= '0;
      tick_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      no_ack_r  <= 1'b0;
      ack_sel_r <= 1'b0;
      rx_hold_r <= '0;
    end else if (in_accept) begin
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      tick_r    <= tick_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      no_ack_r  <= no_ack_nxt;
      ack_sel_r <= ack_sel_nxt;
      rx_hold_r <= rx_hold_nxt;
    end
  end

  // phase length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= DEFAULT_PHASE_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks_r <= cfg_data;
    end
  end

  // result register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hw/rtl/i2cbm_checker.sv */
// port-level checks for the i2c bit-level master, bound to the top level
module i2cbm_checker
  import i2cbm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every accepted tick yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result");

  // a finished sequence leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE] |-> !out_tdata[OUT_BUSY])
    else $error("done while still busy");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/i2c_bit_level_master_test.sv */
// self-checking testbench for the i2c bit-level master: bus tick stream against a local predictor
module i2c_bit_level_master_test;
  import i2cbm_pkg::*;

  // one bus tick as it goes into the block
  typedef struct packed {
    cmd_t             cmd;
    logic [ByteW-1:0] tx_byte;
    logic             send_ack;
    logic             sda_in;
  } bus_tick_t;

  // bus levels and status reported for one tick
  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx_byte;
    logic             no_ack;
  } bus_levels_t;

  // how the sda_in line behaves while a sequence runs
  localparam int LINE_LOW  = 0;
  localparam int LINE_HIGH = 1;
  localparam int LINE_RAND = 2;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [TickW-1:0]    cfg_data   = '0;

  bus_tick_t   pending_ticks[$];   // ticks still to be offered to the block
  bus_levels_t expected_levels[$]; // predicted results, oldest first
  bus_tick_t   tick_on_bus;        // tick currently held on the input stream
  bus_levels_t seen, wanted;
  int unsigned mismatches = 0;
  int unsigned ticks_made = 0;
  bit          steady     = 1'b0;  // set for a stretch with no idling on either side

  // predictor state: its own copy of the engine
  logic [TickW-1:0] phase_len;
  cmd_t             run_cmd;
  phase_t           run_phase;
  logic [ByteW-1:0] shift_q;
  logic [TickW-1:0] tick_cnt;
  logic             scl_q, sda_q;
  logic             nack_q;        // acknowledge seen by the last finished write
  logic             ack_q;         // send_ack latched when the command was taken
  logic [ByteW-1:0] rx_q;

  i2c_bit_level_master u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // advance the engine copy by one tick and return the levels it reports
  function automatic bus_levels_t predict_bus_tick(bus_tick_t t);
    logic [TickW-1:0] span;
    phase_t           p;
    phase_t           final_phase;
    bus_levels_t      r;
    span   = (phase_len == '0) ? TickW'(1) : phase_len;
    r.done = 1'b0;
    // a command is taken only while idle; unknown codes are dropped
    if (run_cmd == CMD_NONE && t.cmd >= CMD_START && t.cmd <= CMD_READ) begin
      run_cmd   = t.cmd;
      run_phase = '0;
      tick_cnt  = '0;
      shift_q   = (t.cmd == CMD_WRITE) ? t.tx_byte : '0;
      ack_q     = t.send_ack;
    end
    if (run_cmd != CMD_NONE) begin
      p = run_phase;
      // levels of the current phase
      case (run_cmd)
        CMD_START: begin
          if (p == 0) {scl_q, sda_q} = 2'b11;
          else if (p == 1) {scl_q, sda_q} = 2'b10;
          else {scl_q, sda_q} = 2'b00;
        end
        CMD_STOP: begin
          // first phase pulls sda low and leaves scl where it was
          if (p == 0) sda_q = 1'b0;
          else if (p == 1) {scl_q, sda_q} = 2'b10;
          else {scl_q, sda_q} = 2'b11;
        end
        CMD_WRITE: begin
          if (p < PH_DATA_END) begin
            scl_q = p[0];
            sda_q = shift_q[ByteW-1];
          end else begin
            scl_q = (p == PH_ACK_HIGH);
            sda_q = 1'b1;
          end
        end
        CMD_READ: begin
          if (p < PH_DATA_END) begin
            scl_q = ~p[0];
            sda_q = 1'b1;
          end else begin
            scl_q = (p == PH_ACK_HIGH);
            sda_q = !(p < PH_LAST_ACK && ack_q);
          end
        end
        default: ;
      endcase
      tick_cnt = tick_cnt + TickW'(1);
      if (tick_cnt >= span) begin
        // end of phase: shift, sample and pick up the acknowledge
        if (run_cmd == CMD_WRITE) begin
          if (p < PH_DATA_END && p[0]) shift_q = shift_q << 1;
          else if (p == PH_ACK_HIGH) nack_q = t.sda_in;
        end else if (run_cmd == CMD_READ && p < PH_DATA_END && !p[0]) begin
          shift_q = {shift_q[ByteW-2:0], t.sda_in};
        end
        tick_cnt = '0;
        if (run_cmd == CMD_START || run_cmd == CMD_STOP) final_phase = PH_LAST_COND;
        else if (run_cmd == CMD_READ && ack_q) final_phase = PH_LAST_ACK;
        else final_phase = PH_LAST_BYTE;
        if (run_phase >= final_phase) begin
          if (run_cmd == CMD_READ) rx_q = shift_q;
          run_cmd   = CMD_NONE;
          run_phase = '0;
          r.done    = 1'b1;
        end else begin
          run_phase = run_phase + PhaseW'(1);
        end
      end
    end
    r.scl     = scl_q;
    r.sda     = sda_q;
    r.busy    = (run_cmd != CMD_NONE);
    r.rx_byte = rx_q;
    r.no_ack  = nack_q;
    return r;
  endfunction

  function automatic int seq_phases(cmd_t c, logic ack);
    case (c)
      CMD_START, CMD_STOP: return 3;
      CMD_WRITE:           return 19;
      CMD_READ:            return ack ? 20 : 19;
      default:             return 1;
    endcase
  endfunction

  function automatic logic line_bit(int mode);
    if (mode == LINE_LOW) return 1'b0;
    if (mode == LINE_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic push_tick(cmd_t c, logic [ByteW-1:0] tx, logic ack, logic sda);
    bus_tick_t t;
    t.cmd      = c;
    t.tx_byte  = tx;
    t.send_ack = ack;
    t.sda_in   = sda;
    pending_ticks.push_back(t);
    ticks_made++;
  endtask

  task automatic push_idle(int n);
    repeat (n) push_tick(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endtask

  // one command tick, then ticks enough for its sequence (less trim), then a few idle ticks;
  // now and then a command lands while busy and must be ignored
  task automatic push_cmd(cmd_t c, logic [ByteW-1:0] tx, logic ack, int mode, int trim);
    int span;
    int fill;
    span = (phase_len == '0) ? 1 : int'(phase_len);
    fill = seq_phases(c, ack) * span - 1 - trim;
    push_tick(c, tx, ack, line_bit(mode));
    repeat ((fill > 0) ? fill : 0) begin
      if ($urandom_range(0, 99) < 8)
        push_tick(cmd_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), line_bit(mode));
      else
        push_tick(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  line_bit(mode));
    end
    push_idle($urandom_range(0, 2));
  endtask

  // random bus transfers: start, address byte, a few data bytes, stop; some noise between
  task automatic push_transfers(int quota);
    int first;
    int trim;
    first = ticks_made;
    while (ticks_made - first < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        push_cmd(cmd_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), LINE_RAND, $urandom_range(0, 3));
      end else begin
        push_cmd(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 LINE_RAND, 0);
        push_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 LINE_RAND, 0);
        repeat ($urandom_range(1, 3)) begin
          // a short byte now and then so the next command hits a busy engine
          trim = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 4) : 0;
          push_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), LINE_RAND, trim);
        end
        push_cmd(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 LINE_RAND, 0);
      end
    end
    // let the last sequence run out before anything else happens
    push_idle(20 * ((phase_len == '0) ? 1 : int'(phase_len)) + 2);
  endtask

  // wait until every tick went in and every result came back
  task automatic drain;
    while (pending_ticks.size() != 0 || in_tvalid || expected_levels.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_phase_len(logic [TickW-1:0] v);
    @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    phase_len = v;
  endtask

  task automatic check_bus_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // input driver: offers the next tick at random, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_levels.push_back(predict_bus_tick(tick_on_bus));
      if (!in_tvalid || in_tready) begin
        if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
          tick_on_bus = pending_ticks.pop_front();
          in_tvalid  <= 1'b1;
          in_tdata   <= {3'b000, tick_on_bus.sda_in, tick_on_bus.send_ack,
                         tick_on_bus.tx_byte, tick_on_bus.cmd};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: each transaction against the oldest expectation, field by field
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.scl     = out_tdata[OUT_SCL];
        seen.sda     = out_tdata[OUT_SDA];
        seen.busy    = out_tdata[OUT_BUSY];
        seen.done    = out_tdata[OUT_DONE];
        seen.rx_byte = out_tdata[OUT_RX_LO +: ByteW];
        seen.no_ack  = out_tdata[OUT_NOACK];
        if (expected_levels.size() == 0) begin
          $display("%0t: result expected none actual %0h", $time, out_tdata);
          mismatches++;
        end else begin
          wanted = expected_levels.pop_front();
          check_bus_field("scl_level", wanted.scl, seen.scl);
          check_bus_field("sda_level", wanted.sda, seen.sda);
          check_bus_field("busy_res", wanted.busy, seen.busy);
          check_bus_field("done_res", wanted.done, seen.done);
          check_bus_field("rx_byte", wanted.rx_byte, seen.rx_byte);
          check_bus_field("no_ack", wanted.no_ack, seen.no_ack);
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    // engine copy after reset
    phase_len = DEFAULT_PHASE_TICKS;
    run_cmd   = CMD_NONE;
    run_phase = '0;
    shift_q   = '0;
    tick_cnt  = '0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    nack_q    = 1'b0;
    ack_q     = 1'b0;
    rx_q      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at one tick per phase
    set_phase_len(16'd1);
    push_cmd(CMD_STOP, 8'h00, 1'b0, LINE_HIGH, 0);   // stop straight from reset, scl still high
    push_cmd(CMD_NONE, 8'hFF, 1'b1, LINE_HIGH, 0);
    push_cmd(cmd_t'(5), 8'h00, 1'b0, LINE_LOW, 0);    // unknown codes while idle
    push_cmd(cmd_t'(6), 8'hFF, 1'b1, LINE_HIGH, 0);
    push_cmd(cmd_t'(7), 8'h5A, 1'b0, LINE_RAND, 0);
    push_cmd(CMD_START, 8'h00, 1'b0, LINE_RAND, 0);
    push_cmd(CMD_WRITE, 8'h00, 1'b0, LINE_LOW, 0);   // acknowledged
    push_cmd(CMD_WRITE, 8'hFF, 1'b1, LINE_HIGH, 0);  // not acknowledged
    push_cmd(CMD_WRITE, 8'hA5, 1'b0, LINE_RAND, 3);  // cut short: the next read hits a busy engine
    push_cmd(CMD_READ, 8'h00, 1'b1, LINE_RAND, 0);
    push_cmd(CMD_READ, 8'h00, 1'b1, LINE_HIGH, 0);   // all ones, acknowledge
    push_cmd(CMD_READ, 8'hFF, 1'b0, LINE_LOW, 0);    // all zeros, no acknowledge
    push_cmd(CMD_READ, 8'h3C, 1'b1, LINE_RAND, 0);
    push_cmd(CMD_STOP, 8'h00, 1'b0, LINE_RAND, 0);   // stop after scl was left low
    push_cmd(CMD_START, 8'h00, 1'b0, LINE_RAND, 0);
    push_cmd(CMD_START, 8'h00, 1'b0, LINE_RAND, 0);  // repeated start
    push_cmd(CMD_STOP, 8'h00, 1'b0, LINE_RAND, 0);
    push_idle(22);
    drain;

    // zero phase length counts as one
    set_phase_len(16'd0);
    push_transfers(60);
    drain;

    // long stretch with both sides always ready
    set_phase_len(16'd2);
    steady = 1'b1;
    push_transfers(100);
    drain;
    steady = 1'b0;

    // longer phase: a single start condition only
    set_phase_len(16'd12);
    push_cmd(CMD_START, 8'h00, 1'b0, LINE_RAND, 0);
    push_idle(4);
    drain;

    set_phase_len(16'd1);
    push_transfers(60);
    drain;

    // wait for the result register to drain
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(8 * 1500000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/i2cbm_pkg.sv
hw/rtl/i2c_bit_level_master.sv
hw/rtl/i2cbm_checker.sv
tb/i2c_bit_level_master_test.sv
